/* sv/rmpc_pkg.sv */
// ----------------------------------------------------------------------------
// rmpc_pkg
// Shared types and constants for the region map protection check block.
// ----------------------------------------------------------------------------
package rmpc_pkg;

    localparam int REGIONS_DEF = 16;
    localparam int ADDR_W      = 32;
    localparam int IDX_OUT_W   = 4;
    localparam int TOTAL_W     = 36;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNMAPPED = 3'd1,
        ST_NOPERM   = 3'd2,
        ST_BOUNDS   = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_FULL     = 3'd5,
        ST_NOBASE   = 3'd6
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] length;
        logic [1:0]        prot_flags;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] region_index;
        logic [ADDR_W-1:0]    offset;
        logic [TOTAL_W-1:0]   total_mapped;
    } t_res;

endpackage

/* sv/region_map_protection_check.sv */
// ----------------------------------------------------------------------------
// region_map_protection_check
// Region table with map, unmap and read/write access checks.
// ----------------------------------------------------------------------------
// The slot scan reads and compares one table slot per cycle, lowest index
// first; after the last slot, a drain step and then a finish step follow.
// busy is high from the accepted request until the result is written, so a
// new request is taken only once the previous one is through.
// Reset (synchronous, active low) empties the table and zeroes the total.
// The result shows for one cycle on o_done; the receiver cannot stall.
module region_map_protection_check
    import rmpc_pkg::*;
#(
    parameter int REGIONS = REGIONS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state;

    // slot storage
    logic [ADDR_W-1:0] r_base_mem [REGIONS];
    logic [ADDR_W-1:0] r_size_mem [REGIONS];
    logic [1:0]        r_perm_mem [REGIONS];
    logic [REGIONS-1:0] r_valid;

    // request and scan control
    t_req              r_req;
    logic [ADDR_W:0]   r_end;
    logic [IDX_W-1:0]  r_idx;

    // read stage
    logic              r_rd_live;
    logic              r_rd_valid;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [ADDR_W-1:0] r_rd_base;
    logic [ADDR_W-1:0] r_rd_size;
    logic [1:0]        r_rd_perm;

    // scan results
    logic              r_hit_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [ADDR_W-1:0] r_hit_base;
    logic [ADDR_W-1:0] r_hit_size;
    logic [ADDR_W:0]   r_hit_end;
    logic [1:0]        r_hit_perm;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;

    logic [TOTAL_W-1:0] r_total;
    logic               r_done;
    t_res               r_res;

    // shared compare unit
    logic [ADDR_W:0] w_old_end;
    logic            w_base_eq;
    logic            w_in_old;
    logic            w_old_in_new;
    logic            w_match;
    logic            w_accept;
    logic            w_write;

    assign w_accept     = start && (r_state == S_IDLE);
    assign w_old_end    = {1'b0, r_rd_base} + {1'b0, r_rd_size};
    assign w_base_eq    = (r_rd_base == r_req.address);
    assign w_in_old     = (r_req.address >= r_rd_base) && ({1'b0, r_req.address} < w_old_end);
    assign w_old_in_new = (r_rd_base >= r_req.address) && ({1'b0, r_rd_base} < r_end);

    always_comb begin
        unique case (r_req.cmd)
            CMD_MAP:   w_match = w_base_eq || w_in_old || w_old_in_new;
            CMD_UNMAP: w_match = w_base_eq;
            default:   w_match = w_in_old;
        endcase
    end

    assign w_write = (r_state == S_FIN) && (r_req.cmd == CMD_MAP)
                     && !r_hit_found && r_free_found;

    // table memory: one read port for the scan, one write port for map
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_base_mem[r_free_idx] <= r_req.address;
            r_size_mem[r_free_idx] <= r_req.length;
            r_perm_mem[r_free_idx] <= r_req.prot_flags;
        end
        r_rd_base <= r_base_mem[r_idx];
        r_rd_size <= r_size_mem[r_idx];
        r_rd_perm <= r_perm_mem[r_idx];
    end

    // outcome of the finish step
    t_status            n_status;
    logic [IDX_W-1:0]   n_index;
    logic [ADDR_W-1:0]  n_offset;
    logic [TOTAL_W-1:0] n_total;
    logic               w_perm_ok;

    assign w_perm_ok = (r_req.cmd == CMD_READ) ? r_hit_perm[0] : r_hit_perm[1];

    always_comb begin
        n_status = ST_OK;
        n_index  = '0;
        n_offset = '0;
        n_total  = r_total;
        unique case (r_req.cmd)
            CMD_MAP: begin
                if (r_hit_found) begin
                    n_status = ST_OVERLAP;
                    n_index  = r_hit_idx;
                end else if (!r_free_found) begin
                    n_status = ST_FULL;
                end else begin
                    n_index = r_free_idx;
                    n_total = r_total + TOTAL_W'(r_req.length);
                end
            end
            CMD_UNMAP: begin
                if (r_hit_found) begin
                    n_index = r_hit_idx;
                    n_total = r_total - TOTAL_W'(r_hit_size);
                end else begin
                    n_status = ST_NOBASE;
                end
            end
            default: begin
                if (!r_hit_found) begin
                    n_status = ST_UNMAPPED;
                end else begin
                    n_index = r_hit_idx;
                    // address >= base, so offset + length > size matches end > slot end
                    if (!w_perm_ok) begin
                        n_status = ST_NOPERM;
                    end else if (r_end > r_hit_end) begin
                        n_status = ST_BOUNDS;
                    end else begin
                        n_offset = r_req.address - r_hit_base;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_total      <= '0;
            r_done       <= 1'b0;
            r_rd_live    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_done    <= (r_state == S_FIN);
            r_rd_live <= (r_state == S_SCAN);
            r_rd_idx  <= r_idx;
            r_rd_valid <= r_valid[r_idx];

            // compare the slot read in the previous cycle; keep the lowest hit
            if (r_rd_live) begin
                if (r_rd_valid && w_match && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_rd_idx;
                    r_hit_base  <= r_rd_base;
                    r_hit_size  <= r_rd_size;
                    r_hit_end   <= w_old_end;
                    r_hit_perm  <= r_rd_perm;
                end
                if (!r_rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req        <= i_req;
                        r_end        <= {1'b0, i_req.address} + {1'b0, i_req.length};
                        r_idx        <= '0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_write) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    if (r_req.cmd == CMD_UNMAP && r_hit_found) begin
                        r_valid[r_hit_idx] <= 1'b0;
                    end
                    r_total                <= n_total;
                    r_res.status           <= n_status;
                    r_res.region_index     <= IDX_OUT_W'(n_index);
                    r_res.offset           <= n_offset;
                    r_res.total_mapped     <= n_total;
                    r_idx                  <= '0;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* test/tb_region_map_protection_check.sv */
// ----------------------------------------------------------------------------
// tb_region_map_protection_check
// Drives map, unmap, read-check and write-check requests into the region
// table. A table model inside the bench predicts each result and the
// checker compares every strobed result with the oldest prediction.
// Directed requests cover the empty table, edge addresses, overlap rules
// and zero-size regions. Random traffic then fills, churns and empties
// the table inside shifting address windows, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_region_map_protection_check;
    import rmpc_pkg::*;

    localparam int NSLOT = REGIONS_DEF;

    localparam logic [1:0] PERM_NONE = 2'b00;
    localparam logic [1:0] PERM_R    = 2'b01;
    localparam logic [1:0] PERM_W    = 2'b10;
    localparam logic [1:0] PERM_RW   = 2'b11;

    typedef enum {MIX_CHURN, MIX_FILL, MIX_DRAIN} t_mix;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_res o_res;

    // Table model; 2-state defaults match the cleared table after reset.
    bit          region_valid [NSLOT];
    bit [31:0]   region_base  [NSLOT];
    bit [31:0]   region_size  [NSLOT];
    bit [1:0]    region_perm  [NSLOT];
    bit [36:0]   mapped_bytes;

    t_res expected_results [$];
    int   mismatch_count = 0;
    bit   no_gaps = 1'b0;

    region_map_protection_check #(
        .REGIONS (NSLOT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("Mismatches found");
        $finish;
    end

    // Region extent is [base, base + size) without wrap.
    function automatic bit covers(logic [31:0] a, logic [31:0] base, logic [31:0] size);
        return ({1'b0, a} >= {1'b0, base}) && ({1'b0, a} < {1'b0, base} + {1'b0, size});
    endfunction

    function automatic t_res apply_command(input t_req req);
        t_res        res;
        int          hit;
        int          free_slot;
        logic [32:0] off;
        logic [1:0]  need;
        res       = '0;
        res.status = ST_OK;
        hit       = -1;
        free_slot = -1;
        case (req.cmd)
            CMD_MAP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (region_valid[i]) begin
                        if (hit < 0 && (region_base[i] == req.address
                                || covers(req.address, region_base[i], region_size[i])
                                || covers(region_base[i], req.address, req.length)))
                            hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    res.status       = ST_OVERLAP;
                    res.region_index = 4'(hit);
                end else if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    region_valid[free_slot] = 1'b1;
                    region_base[free_slot]  = req.address;
                    region_size[free_slot]  = req.length;
                    region_perm[free_slot]  = req.prot_flags;
                    mapped_bytes += req.length;
                    res.region_index = 4'(free_slot);
                end
            end
            CMD_UNMAP: begin
                res.status = ST_NOBASE;
                for (int i = 0; i < NSLOT; i++)
                    if (hit < 0 && region_valid[i] && region_base[i] == req.address)
                        hit = i;
                if (hit >= 0) begin
                    region_valid[hit] = 1'b0;
                    mapped_bytes -= region_size[hit];
                    res.status       = ST_OK;
                    res.region_index = 4'(hit);
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++)
                    if (hit < 0 && region_valid[i]
                            && covers(req.address, region_base[i], region_size[i]))
                        hit = i;
                if (hit < 0) begin
                    res.status = ST_UNMAPPED;
                end else begin
                    need = (req.cmd == CMD_READ) ? PERM_R : PERM_W;
                    off  = {1'b0, req.address} - {1'b0, region_base[hit]};
                    res.region_index = 4'(hit);
                    if ((region_perm[hit] & need) == PERM_NONE)
                        res.status = ST_NOPERM;
                    else if (off + {1'b0, req.length} > {1'b0, region_size[hit]})
                        res.status = ST_BOUNDS;
                    else
                        res.offset = off[31:0];
                end
            end
        endcase
        res.total_mapped = mapped_bytes[35:0];
        return res;
    endfunction

    function automatic int field_mismatch(string name, logic [35:0] want, logic [35:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check results first, then predict the request taken at this edge.
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request pending, status 0x%0h", o_res.status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    mismatch_count += field_mismatch("status", want.status, o_res.status);
                    mismatch_count += field_mismatch("region_index", want.region_index,
                                                     o_res.region_index);
                    mismatch_count += field_mismatch("offset", want.offset, o_res.offset);
                    mismatch_count += field_mismatch("total_mapped", want.total_mapped,
                                                     o_res.total_mapped);
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_command(i_req));
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 16);
        return $urandom_range(30, 80);
    endfunction

    // Hold start high until the request is taken; keep it high for back-to-back.
    task automatic send_request(input t_req req);
        int gap;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req req_of(t_cmd c, logic [31:0] a, logic [31:0] l,
                                    logic [1:0] p);
        t_req req;
        req.cmd        = c;
        req.address    = a;
        req.length     = l;
        req.prot_flags = p;
        return req;
    endfunction

    task automatic test_empty_table();
        send_request(req_of(CMD_READ, 32'h0, 32'h0, PERM_NONE));
        send_request(req_of(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PERM_RW));
        send_request(req_of(CMD_UNMAP, 32'hDEAD_0000, 32'h0, PERM_NONE));
    endtask

    task automatic test_address_extremes();
        // region end lies above 4 GiB
        send_request(req_of(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PERM_RW));
        send_request(req_of(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PERM_NONE));
        send_request(req_of(CMD_READ, 32'hFFFF_FFFF, 32'h0, PERM_NONE));
        // ends exactly where the top region starts
        send_request(req_of(CMD_MAP, 32'h0, 32'hFFFF_FFFF, PERM_W));
        send_request(req_of(CMD_READ, 32'hFFFF_FFFE, 32'h1, PERM_NONE));
        send_request(req_of(CMD_UNMAP, 32'h0, 32'h0, PERM_NONE));
        send_request(req_of(CMD_UNMAP, 32'hFFFF_FFFF, 32'h0, PERM_NONE));
    endtask

    task automatic test_map_and_check();
        send_request(req_of(CMD_MAP, 32'h1000, 32'h100, PERM_R));
        send_request(req_of(CMD_READ, 32'h10FF, 32'h1, PERM_NONE));
        send_request(req_of(CMD_READ, 32'h10FF, 32'h2, PERM_NONE));
        send_request(req_of(CMD_WRITE, 32'h1000, 32'h4, PERM_NONE));
        // equal base, then a new region enclosing the old one
        send_request(req_of(CMD_MAP, 32'h1000, 32'h0, PERM_RW));
        send_request(req_of(CMD_MAP, 32'h0F00, 32'h400, PERM_RW));
        send_request(req_of(CMD_MAP, 32'h1100, 32'h10, PERM_RW));
        // zero-size region: mappable, never hit, still blocks its base
        send_request(req_of(CMD_MAP, 32'h5000, 32'h0, PERM_RW));
        send_request(req_of(CMD_READ, 32'h5000, 32'h0, PERM_NONE));
        send_request(req_of(CMD_MAP, 32'h5000, 32'h10, PERM_RW));
        send_request(req_of(CMD_UNMAP, 32'h1000, 32'h0, PERM_NONE));
        send_request(req_of(CMD_WRITE, 32'h1108, 32'h8, PERM_NONE));
        send_request(req_of(CMD_UNMAP, 32'h1000, 32'h0, PERM_NONE));
    endtask

    function automatic t_req make_request(input t_mix mix, input logic [31:0] window);
        t_req        req;
        int          r;
        int          map_pct;
        int          unmap_pct;
        int          s;
        int          live [$];
        logic [31:0] off;
        for (int i = 0; i < NSLOT; i++)
            if (region_valid[i]) live.push_back(i);
        case (mix)
            MIX_FILL:  begin map_pct = 55; unmap_pct = 5;  end
            MIX_DRAIN: begin map_pct = 10; unmap_pct = 45; end
            default:   begin map_pct = 30; unmap_pct = 15; end
        endcase
        req.prot_flags = 2'($urandom_range(0, 3));
        req.address    = window + $urandom_range(0, 'hFFFF);
        req.length     = $urandom_range(0, 'h1000);
        r = $urandom_range(0, 99);
        if (r < map_pct) begin
            req.cmd = CMD_MAP;
            if ($urandom_range(0, 9) == 0) req.length = 32'h0;
        end else if (r < map_pct + unmap_pct) begin
            req.cmd = CMD_UNMAP;
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
                req.address = region_base[live[$urandom_range(0, live.size() - 1)]];
        end else begin
            req.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
            if (live.size() > 0 && $urandom_range(0, 9) < 8) begin
                s = live[$urandom_range(0, live.size() - 1)];
                // aim inside the region or just past its end
                if (region_size[s] == 0)
                    off = 32'h0;
                else if ($urandom_range(0, 9) < 7)
                    off = $urandom_range(0, region_size[s] - 1);
                else
                    off = region_size[s] + $urandom_range(0, 3);
                req.address = region_base[s] + off;
                if ($urandom_range(0, 9) < 3)
                    req.length = region_size[s] - off + $urandom_range(0, 2) - 1;
                else
                    req.length = $urandom_range(0, 64);
            end
        end
        // rare full-width values
        r = $urandom_range(0, 99);
        if (r < 3)
            req.address = $urandom();
        else if (r < 6)
            req.length = $urandom();
        return req;
    endfunction

    task automatic test_random_traffic(input int count, input t_mix mix);
        logic [31:0] window;
        window  = $urandom();
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) send_request(make_request(mix, window));
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_address_extremes();
        test_map_and_check();
        wait_results_drained();
        for (int phase = 0; phase < 10; phase++) begin
            test_random_traffic(60, MIX_FILL);
            test_random_traffic(50, MIX_CHURN);
            test_random_traffic(40, MIX_DRAIN);
            if (phase % 3 == 0) wait_results_drained();
        end
        wait_results_drained();
        repeat (NSLOT + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
